// ===== design/mic1_pkg.sv =====
package mic1_pkg;

	localparam int MEM_ADDR_BITS = 16;
	localparam int ROW_BITS = MEM_ADDR_BITS - 2;
	localparam int ROWS = 1 << ROW_BITS;

	typedef logic [MEM_ADDR_BITS-1:0] maddr_t;
	typedef logic [ROW_BITS-1:0] row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WB
	} state_t;

	typedef struct packed {
		logic       exec;
		logic       wb;
		logic       fetch;
		logic       rd;
		logic [2:0] jam;
		logic [8:0] nad;
	} ctrl_t;

	localparam logic [3:0] B_MDR = 4'd0;
	localparam logic [3:0] B_PC = 4'd1;
	localparam logic [3:0] B_MBR = 4'd2;
	localparam logic [3:0] B_MBRS = 4'd3;
	localparam logic [3:0] B_SP = 4'd4;
	localparam logic [3:0] B_LV = 4'd5;
	localparam logic [3:0] B_CPP = 4'd6;
	localparam logic [3:0] B_TOS = 4'd7;
	localparam logic [3:0] B_OPC = 4'd8;

	localparam int WE_MAR = 0;
	localparam int WE_MDR = 1;
	localparam int WE_PC = 2;
	localparam int WE_SP = 3;
	localparam int WE_LV = 4;
	localparam int WE_CPP = 5;
	localparam int WE_TOS = 6;
	localparam int WE_OPC = 7;
	localparam int WE_H = 8;

	localparam int MOP_FETCH = 0;
	localparam int MOP_READ = 1;
	localparam int MOP_WRITE = 2;

	localparam int JAM_Z = 0;
	localparam int JAM_N = 1;
	localparam int JAM_PC = 2;

	localparam logic [5:0] ALU_A = 6'h18;
	localparam logic [5:0] ALU_B = 6'h14;
	localparam logic [5:0] ALU_NOT_A = 6'h1A;
	localparam logic [5:0] ALU_NOT_B = 6'h2C;
	localparam logic [5:0] ALU_ADD = 6'h3C;
	localparam logic [5:0] ALU_ADD_INC = 6'h3D;
	localparam logic [5:0] ALU_INC_A = 6'h39;
	localparam logic [5:0] ALU_INC_B = 6'h35;
	localparam logic [5:0] ALU_SUB = 6'h3F;
	localparam logic [5:0] ALU_DEC_B = 6'h36;
	localparam logic [5:0] ALU_NEG_A = 6'h3B;
	localparam logic [5:0] ALU_AND = 6'h0C;
	localparam logic [5:0] ALU_OR = 6'h1C;
	localparam logic [5:0] ALU_ZERO = 6'h10;
	localparam logic [5:0] ALU_ONE = 6'h31;
	localparam logic [5:0] ALU_MINUS1 = 6'h32;

endpackage

// ===== design/mic1_mem.sv =====
module mic1_mem
	import mic1_pkg::*;
(
	input  logic        clk,
	input  logic        rd_en,
	input  row_t        word_row,
	input  maddr_t      fetch_addr,
	input  logic        wr_en,
	input  logic [31:0] wr_data,
	input  logic        load_en,
	input  maddr_t      load_addr,
	input  logic [7:0]  load_data,
	output logic [31:0] rd_word,
	output logic [7:0]  rd_byte
);

	// Four byte lanes; a word at MAR*4 always occupies one row of all four lanes.
	logic [7:0] fetch_lane_q [4];
	logic [1:0] fetch_sel_q;
	row_t       fetch_row;

	assign fetch_row = fetch_addr[MEM_ADDR_BITS-1:2];

	for (genvar b = 0; b < 4; b++) begin : g_lane
		logic [7:0] ram_q [ROWS];
		logic [7:0] rdw_q;
		logic       we;
		row_t       waddr;
		logic [7:0] wdata;

		always_comb begin
			we = wr_en || (load_en && (load_addr[1:0] == 2'(b)));
			waddr = load_en ? load_addr[MEM_ADDR_BITS-1:2] : word_row;
			wdata = load_en ? load_data : wr_data[8*b +: 8];
		end

		always_ff @(posedge clk) begin
			if (we) begin
				ram_q[waddr] <= wdata;
			end
			if (rd_en) begin
				rdw_q <= ram_q[word_row];
				fetch_lane_q[b] <= ram_q[fetch_row];
			end
		end

		assign rd_word[8*b +: 8] = rdw_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fetch_sel_q <= fetch_addr[1:0];
		end
	end

	assign rd_byte = fetch_lane_q[fetch_sel_q];

endmodule

// ===== design/mic1_dpath.sv =====
module mic1_dpath
	import mic1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctl,
	input  logic [35:0] micro_word,
	input  logic [31:0] rd_word,
	input  logic [7:0]  rd_byte,
	output logic [31:0] wr_data,
	output logic [8:0]  next_micro_address,
	output logic [31:0] reg_pc,
	output logic [31:0] reg_mar,
	output logic [31:0] reg_mdr,
	output logic [31:0] reg_sp,
	output logic [31:0] reg_lv,
	output logic [31:0] reg_cpp,
	output logic [31:0] reg_tos,
	output logic [31:0] reg_hold,
	output logic [7:0]  reg_mbr,
	output logic        flag_negative,
	output logic        flag_zero
);

	logic [31:0] mar_q, mdr_q, pc_q, sp_q, lv_q, cpp_q, tos_q, opc_q, h_q, alu_q;
	logic [7:0]  mbr_q;
	logic        n_q, z_q;
	logic [8:0]  upc_q;

	logic [3:0]  bsrc;
	logic [8:0]  wen;
	logic [5:0]  fn;
	logic [1:0]  sh;
	logic [31:0] bbus, alu_d, cbus;
	logic [7:0]  mbr_d;
	logic [8:0]  upc_d;

	assign bsrc = micro_word[3:0];
	assign wen = micro_word[15:7];
	assign fn = micro_word[21:16];
	assign sh = micro_word[23:22];

	always_comb begin
		case (bsrc)
			B_MDR:   bbus = mdr_q;
			B_PC:    bbus = pc_q;
			B_MBR:   bbus = {24'd0, mbr_q};
			B_MBRS:  bbus = {{24{mbr_q[7]}}, mbr_q};
			B_SP:    bbus = sp_q;
			B_LV:    bbus = lv_q;
			B_CPP:   bbus = cpp_q;
			B_TOS:   bbus = tos_q;
			B_OPC:   bbus = opc_q;
			default: bbus = 32'hFFFF_FFFF;
		endcase
	end

	always_comb begin
		case (fn)
			ALU_A:       alu_d = h_q;
			ALU_B:       alu_d = bbus;
			ALU_NOT_A:   alu_d = ~h_q;
			ALU_NOT_B:   alu_d = ~bbus;
			ALU_ADD:     alu_d = h_q + bbus;
			ALU_ADD_INC: alu_d = h_q + bbus + 32'd1;
			ALU_INC_A:   alu_d = h_q + 32'd1;
			ALU_INC_B:   alu_d = bbus + 32'd1;
			ALU_SUB:     alu_d = bbus - h_q;
			ALU_DEC_B:   alu_d = bbus - 32'd1;
			ALU_NEG_A:   alu_d = 32'd0 - h_q;
			ALU_AND:     alu_d = h_q & bbus;
			ALU_OR:      alu_d = h_q | bbus;
			ALU_ZERO:    alu_d = 32'd0;
			ALU_ONE:     alu_d = 32'd1;
			ALU_MINUS1:  alu_d = 32'hFFFF_FFFF;
			default:     alu_d = alu_q;
		endcase
	end

	always_comb begin
		if (sh[1]) begin
			cbus = {alu_d[23:0], 8'd0};
		end else if (sh[0]) begin
			cbus = {1'b0, alu_d[31:1]};
		end else begin
			cbus = alu_d;
		end
	end

	// A word write stores MDR as left by a read in the same step.
	assign wr_data = ctl.rd ? rd_word : mdr_q;
	assign mbr_d = ctl.fetch ? rd_byte : mbr_q;

	always_comb begin
		upc_d = ctl.nad;
		if (ctl.jam[JAM_Z]) begin
			upc_d[8] = upc_d[8] | z_q;
		end
		if (ctl.jam[JAM_N]) begin
			upc_d[8] = upc_d[8] | n_q;
		end
		if (ctl.jam[JAM_PC]) begin
			upc_d = upc_d | {1'b0, mbr_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mar_q <= '0;
			mdr_q <= '0;
			pc_q <= '0;
			sp_q <= '0;
			lv_q <= '0;
			cpp_q <= '0;
			tos_q <= '0;
			opc_q <= '0;
			h_q <= '0;
			alu_q <= '0;
			mbr_q <= '0;
			n_q <= 1'b0;
			z_q <= 1'b1;
			upc_q <= '0;
		end else if (ctl.exec) begin
			alu_q <= alu_d;
			n_q <= alu_d[31];
			z_q <= (alu_d == 32'd0);
			if (wen[WE_MAR]) mar_q <= cbus;
			if (wen[WE_MDR]) mdr_q <= cbus;
			if (wen[WE_PC]) pc_q <= cbus;
			if (wen[WE_SP]) sp_q <= cbus;
			if (wen[WE_LV]) lv_q <= cbus;
			if (wen[WE_CPP]) cpp_q <= cbus;
			if (wen[WE_TOS]) tos_q <= cbus;
			if (wen[WE_OPC]) opc_q <= cbus;
			if (wen[WE_H]) h_q <= cbus;
		end else if (ctl.wb) begin
			mdr_q <= wr_data;
			mbr_q <= mbr_d;
			upc_q <= upc_d;
		end
	end

	assign next_micro_address = upc_q;
	assign reg_pc = pc_q;
	assign reg_mar = mar_q;
	assign reg_mdr = mdr_q;
	assign reg_sp = sp_q;
	assign reg_lv = lv_q;
	assign reg_cpp = cpp_q;
	assign reg_tos = tos_q;
	assign reg_hold = h_q;
	assign reg_mbr = mbr_q;
	assign flag_negative = n_q;
	assign flag_zero = z_q;

endmodule

// ===== design/mic1_microinstruction_step.sv =====
// One step of a microprogrammed stack machine data path.
// A word is taken at a rising edge where start is high and busy is low.
// With func low the word carries a 36-bit microinstruction: the ALU, the
// shifter and the register writes complete at that edge, the memory is read
// in the following cycle, and the fetched byte, MDR, any word write and the
// next microinstruction address are settled in the cycle after that. The
// result word appears with done after the read and write-back states, and
// busy is high in both of them, so no new word is taken until the result
// is out; the registered read of the byte-lane memory sets this.
// With func high the word writes one byte of main memory at the accepting
// edge and the unchanged state is shown with done in the next cycle, while
// busy stays low.
// The result is on the output ports for exactly the cycle in which done is
// high; the receiver cannot hold it off. The ports keep their values until
// the next word is accepted.
// Reset clears every register and sets the Z flag; the main memory is not
// cleared and must be loaded before it is read.
module mic1_microinstruction_step
	import mic1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [35:0] micro_word,
	input  logic [15:0] load_address,
	input  logic [7:0]  load_data,
	output logic        done,
	output logic [8:0]  next_micro_address,
	output logic [31:0] reg_pc,
	output logic [31:0] reg_mar,
	output logic [31:0] reg_mdr,
	output logic [31:0] reg_sp,
	output logic [31:0] reg_lv,
	output logic [31:0] reg_cpp,
	output logic [31:0] reg_tos,
	output logic [31:0] reg_hold,
	output logic [7:0]  reg_mbr,
	output logic        flag_negative,
	output logic        flag_zero
);

	state_t      state_q, state_d;
	logic        done_q;
	logic [2:0]  mops_q, jam_q;
	logic [8:0]  nad_q;
	logic        accept, rd_en, wr_en, in_wb;
	ctrl_t       ctl;
	logic [31:0] rd_word, wr_data;
	logic [7:0]  rd_byte;

	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !func) state_d = ST_READ;
			end
			ST_READ: state_d = ST_WB;
			ST_WB:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		rd_en = 1'b0;
		in_wb = 1'b0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_READ: rd_en = 1'b1;
			ST_WB:   in_wb = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	assign wr_en = in_wb && mops_q[MOP_WRITE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			mops_q <= '0;
			jam_q <= '0;
			nad_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= (accept && func) || in_wb;
			if (accept && !func) begin
				mops_q <= micro_word[6:4];
				jam_q <= micro_word[26:24];
				nad_q <= micro_word[35:27];
			end
		end
	end

	always_comb begin
		ctl.exec = accept && !func;
		ctl.wb = in_wb;
		ctl.fetch = mops_q[MOP_FETCH];
		ctl.rd = mops_q[MOP_READ];
		ctl.jam = jam_q;
		ctl.nad = nad_q;
	end

	mic1_mem u_mem (
		.clk        (clk),
		.rd_en      (rd_en),
		.word_row   (reg_mar[ROW_BITS-1:0]),
		.fetch_addr (reg_pc[MEM_ADDR_BITS-1:0]),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.load_en    (accept && func),
		.load_addr  (maddr_t'(load_address)),
		.load_data  (load_data),
		.rd_word    (rd_word),
		.rd_byte    (rd_byte)
	);

	mic1_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.micro_word         (micro_word),
		.rd_word            (rd_word),
		.rd_byte            (rd_byte),
		.wr_data            (wr_data),
		.next_micro_address (next_micro_address),
		.reg_pc             (reg_pc),
		.reg_mar            (reg_mar),
		.reg_mdr            (reg_mdr),
		.reg_sp             (reg_sp),
		.reg_lv             (reg_lv),
		.reg_cpp            (reg_cpp),
		.reg_tos            (reg_tos),
		.reg_hold           (reg_hold),
		.reg_mbr            (reg_mbr),
		.flag_negative      (flag_negative),
		.flag_zero          (flag_zero)
	);

	assign done = done_q;

endmodule

// ===== design/mic1_checker.sv =====
module mic1_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic func,
	input logic done
);

	// A result word is never shown while a microinstruction is in flight.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done raised while busy");

	// A load word is answered in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func) |=> (done && !busy))
		else $error("load word not answered in one cycle");

	// A microinstruction holds busy through its read and write-back states and is then answered with done.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !func) |=> busy ##1 busy ##1 done)
		else $error("microinstruction latency wrong");

	// Busy only rises because a microinstruction was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !func))
		else $error("busy rose without a microinstruction");

endmodule

bind mic1_microinstruction_step mic1_checker u_chk (.*);
